FILE: rtl/pressure_temperature_compensation_assert.svh
// Assertion macros shared by the checker of the compensation block.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_ASSERT_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_ASSERT_SVH

// The antecedent implies the consequent at every clock edge outside reset.
`define PTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The condition never holds outside reset.
`define PTC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

FILE: rtl/ptc_pkg.sv
// Package with types, constants and helpers of the compensation block.
`timescale 1ns / 1ps
`default_nettype none
package ptc_pkg;

  localparam int unsigned CalWidth    = 48;
  localparam int unsigned OffWidth    = 18;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned DivBits     = 32;
  localparam int unsigned Latency     = 47;

  typedef enum logic [CfgIdxWidth-1:0] {
    RegTempCal = 3'd0,
    RegPressA  = 3'd1,
    RegPressB  = 3'd2,
    RegPressC  = 3'd3,
    RegOffset  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
  } in_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic signed [31:0] fine_temperature;
    logic        [31:0] pressure_pa;
    logic signed [31:0] adjusted_pressure_pa;
    logic               pressure_invalid;
  } out_t;

  typedef struct packed {
    logic signed [31:0] temp_centi;
    logic signed [31:0] fine;
    logic        [19:0] raw_pressure;
  } temp_res_t;

  typedef struct packed {
    logic signed [31:0] temp_centi;
    logic signed [31:0] fine;
    logic               invalid;
  } div_side_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] num;
    logic [31:0] quo;
    logic [31:0] den;
    logic        post;
    div_side_t   side;
  } div_stage_t;

  // Zero-extended 16-bit calibration word k.
  function automatic logic [31:0] cal_word_u(input logic [CalWidth-1:0] cal,
                                             input int unsigned k);
    return {16'd0, cal[16*k +: 16]};
  endfunction

  // Sign-extended 16-bit calibration word k.
  function automatic logic signed [31:0] cal_word_s(input logic [CalWidth-1:0] cal,
                                                    input int unsigned k);
    logic [15:0] w;
    w = cal[16*k +: 16];
    return $signed({{16{w[15]}}, w});
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ptc_temp.sv
// Temperature compensation pipeline producing the fine term and temperature.
`timescale 1ns / 1ps
`default_nettype none
module ptc_temp (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  input  wire ptc_pkg::in_t                 in_i,
  input  wire logic [ptc_pkg::CalWidth-1:0] temp_cal_i,
  output logic                              valid_o,
  output ptc_pkg::temp_res_t                res_o
);

  logic        [31:0] t1;
  logic signed [31:0] t2, t3;

  logic [4:0] v_q;
  logic [19:0] rp1_q, rp2_q, rp3_q, rp4_q;

  logic signed [31:0] x1_d, x1_q, d_d, d_q;
  logic signed [31:0] m1_d, m1_q, dd_d, dd_q;
  logic signed [31:0] a_d, a_q, q_d, q_q;
  logic signed [31:0] fine_d, fine_q;
  logic signed [31:0] f5, temp_d;
  ptc_pkg::temp_res_t res_q;

  assign t1 = ptc_pkg::cal_word_u(temp_cal_i, 0);
  assign t2 = ptc_pkg::cal_word_s(temp_cal_i, 1);
  assign t3 = ptc_pkg::cal_word_s(temp_cal_i, 2);

  always_comb begin
    x1_d   = $signed({15'd0, in_i.raw_temperature[19:3]} - (t1 << 1));
    d_d    = $signed({16'd0, in_i.raw_temperature[19:4]} - t1);
    m1_d   = x1_q * t2;
    dd_d   = d_q * d_q;
    a_d    = m1_q >>> 11;
    q_d    = (dd_q >>> 12) * t3;
    fine_d = a_q + (q_q >>> 14);
    f5     = (fine_q <<< 2) + fine_q + 32'sd128;
    temp_d = f5 >>> 8;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q  <= x1_d;
    d_q   <= d_d;
    rp1_q <= in_i.raw_pressure;
    m1_q  <= m1_d;
    dd_q  <= dd_d;
    rp2_q <= rp1_q;
    a_q   <= a_d;
    q_q   <= q_d;
    rp3_q <= rp2_q;
    fine_q <= fine_d;
    rp4_q <= rp3_q;
    res_q.temp_centi   <= temp_d;
    res_q.fine         <= fine_q;
    res_q.raw_pressure <= rp4_q;
  end

  assign valid_o = v_q[4];
  assign res_o   = res_q;

endmodule
`default_nettype wire

FILE: rtl/ptc_coef.sv
// Pressure polynomial pipeline producing the scaled dividend and the divisor.
`timescale 1ns / 1ps
`default_nettype none
module ptc_coef (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  input  wire ptc_pkg::temp_res_t           res_i,
  input  wire logic [ptc_pkg::CalWidth-1:0] cal_a_i,
  input  wire logic [ptc_pkg::CalWidth-1:0] cal_b_i,
  output logic                              valid_o,
  output ptc_pkg::div_side_t                side_o,
  output logic [31:0]                       pnum_o,
  output logic [31:0]                       div_o
);

  logic        [31:0] p1;
  logic signed [31:0] p2, p3, p4, p5, p6;

  logic [5:0] v_q;
  ptc_pkg::temp_res_t sd_q [5];

  logic signed [31:0] a2_d, a2_q;
  logic signed [31:0] a2s, sq_d, sq_q, ap5_d, ap5_q, p2a_d, p2a_q;
  logic signed [31:0] ap5h_q, p2ah_q;
  logic signed [31:0] b_d, b_q, p3s_d, p3s_q;
  logic signed [31:0] b3_d, b3_q, b3h_q, a3_d, a3_q;
  logic signed [31:0] prod_d, prod_q;
  logic signed [31:0] divv;
  logic signed [31:0] b3s;
  logic        [31:0] pnum_d;
  ptc_pkg::div_side_t side_q;
  logic        [31:0] pnum_q, div_q;

  assign p1 = ptc_pkg::cal_word_u(cal_a_i, 0);
  assign p2 = ptc_pkg::cal_word_s(cal_a_i, 1);
  assign p3 = ptc_pkg::cal_word_s(cal_a_i, 2);
  assign p4 = ptc_pkg::cal_word_s(cal_b_i, 0);
  assign p5 = ptc_pkg::cal_word_s(cal_b_i, 1);
  assign p6 = ptc_pkg::cal_word_s(cal_b_i, 2);

  always_comb begin
    a2_d   = (res_i.fine >>> 1) - 32'sd64000;
    a2s    = a2_q >>> 2;
    sq_d   = a2s * a2s;
    ap5_d  = a2_q * p5;
    p2a_d  = p2 * a2_q;
    b_d    = (sq_q >>> 11) * p6;
    p3s_d  = p3 * (sq_q >>> 13);
    b3_d   = ((b_q + (ap5h_q <<< 1)) >>> 2) + (p4 <<< 16);
    a3_d   = ((p3s_q >>> 3) + (p2ah_q >>> 1)) >>> 18;
    prod_d = $signed((32'd32768 + a3_q) * p1);
    divv   = prod_q >>> 15;
    // The shift is kept apart so that it stays arithmetic.
    b3s    = b3h_q >>> 12;
    pnum_d = ((32'd1048576 - {12'd0, sd_q[4].raw_pressure}) - b3s) * 32'd3125;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    sd_q[0] <= res_i;
    sd_q[1] <= sd_q[0];
    sd_q[2] <= sd_q[1];
    sd_q[3] <= sd_q[2];
    sd_q[4] <= sd_q[3];
    a2_q   <= a2_d;
    sq_q   <= sq_d;
    ap5_q  <= ap5_d;
    p2a_q  <= p2a_d;
    b_q    <= b_d;
    p3s_q  <= p3s_d;
    ap5h_q <= ap5_q;
    p2ah_q <= p2a_q;
    b3_q   <= b3_d;
    a3_q   <= a3_d;
    prod_q <= prod_d;
    b3h_q  <= b3_q;
    side_q.temp_centi <= sd_q[4].temp_centi;
    side_q.fine       <= sd_q[4].fine;
    side_q.invalid    <= (divv == 32'sd0);
    pnum_q <= pnum_d;
    div_q  <= divv;
  end

  assign valid_o = v_q[5];
  assign side_o  = side_q;
  assign pnum_o  = pnum_q;
  assign div_o   = div_q;

endmodule
`default_nettype wire

FILE: rtl/ptc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module ptc_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire logic [31:0]        pnum_i,
  input  wire logic [31:0]        div_i,
  input  wire ptc_pkg::div_side_t side_i,
  output logic                    valid_o,
  output logic [31:0]             quot_o,
  output ptc_pkg::div_side_t      side_o
);

  logic [ptc_pkg::DivBits:0] v_q;
  ptc_pkg::div_stage_t stg_q [ptc_pkg::DivBits+1];
  ptc_pkg::div_stage_t stg_d [ptc_pkg::DivBits];
  ptc_pkg::div_stage_t in_d;

  // A dividend below 2^31 is doubled before the division; a larger one is
  // divided as is and the quotient doubled afterward.
  always_comb begin
    in_d.rem  = '0;
    in_d.quo  = '0;
    in_d.den  = div_i;
    in_d.side = side_i;
    in_d.post = pnum_i[31];
    in_d.num  = pnum_i[31] ? pnum_i : (pnum_i << 1);
  end

  for (genvar i = 0; i < ptc_pkg::DivBits; i++) begin : g_stage
    logic [32:0] shifted, trial;
    always_comb begin
      shifted  = {stg_q[i].rem, stg_q[i].num[31]};
      trial    = shifted - {1'b0, stg_q[i].den};
      stg_d[i] = stg_q[i];
      stg_d[i].num = stg_q[i].num << 1;
      if (!trial[32]) begin
        stg_d[i].rem = trial[31:0];
        stg_d[i].quo = {stg_q[i].quo[30:0], 1'b1};
      end else begin
        stg_d[i].rem = shifted[31:0];
        stg_d[i].quo = {stg_q[i].quo[30:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      stg_q[i+1] <= stg_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    stg_q[0] <= in_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[ptc_pkg::DivBits-1:0], valid_i};
    end
  end

  assign valid_o = v_q[ptc_pkg::DivBits];
  assign quot_o  = stg_q[ptc_pkg::DivBits].post ? (stg_q[ptc_pkg::DivBits].quo << 1)
                                                : stg_q[ptc_pkg::DivBits].quo;
  assign side_o  = stg_q[ptc_pkg::DivBits].side;

endmodule
`default_nettype wire

FILE: rtl/ptc_final.sv
// Second-order pressure correction and offset, ending in the result register.
`timescale 1ns / 1ps
`default_nettype none
module ptc_final (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  input  wire logic [31:0]                  quot_i,
  input  wire ptc_pkg::div_side_t           side_i,
  input  wire logic [ptc_pkg::CalWidth-1:0] cal_c_i,
  input  wire logic [ptc_pkg::OffWidth-1:0] offset_i,
  output logic                              valid_o,
  output ptc_pkg::out_t                     res_o
);

  logic signed [31:0] p7, p8, p9, off;
  logic [2:0] v_q;

  logic [31:0] s3, p1_q, sq2_d, sq2_q, p2_q;
  logic signed [31:0] pb_d, pb_q;
  logic signed [31:0] ta_d, ta_q, tb_d, tb_q;
  logic signed [31:0] corr;
  logic [31:0] pf;
  ptc_pkg::div_side_t sd1_q, sd2_q;
  ptc_pkg::out_t res_q;

  assign p7  = ptc_pkg::cal_word_s(cal_c_i, 0);
  assign p8  = ptc_pkg::cal_word_s(cal_c_i, 1);
  assign p9  = ptc_pkg::cal_word_s(cal_c_i, 2);
  assign off = 32'(signed'(offset_i));

  always_comb begin
    s3    = quot_i >> 3;
    sq2_d = s3 * s3;
    pb_d  = $signed((quot_i >> 2) * p8);
    ta_d  = $signed(p9 * (sq2_q >> 13)) >>> 12;
    tb_d  = pb_q >>> 13;
    corr  = (ta_q + tb_q + p7) >>> 4;
    pf    = p2_q + corr;
    if (sd2_q.invalid) begin
      pf = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q  <= quot_i;
    sq2_q <= sq2_d;
    pb_q  <= pb_d;
    sd1_q <= side_i;
    p2_q  <= p1_q;
    ta_q  <= ta_d;
    tb_q  <= tb_d;
    sd2_q <= sd1_q;
    res_q.temperature_centi    <= sd2_q.temp_centi;
    res_q.fine_temperature     <= sd2_q.fine;
    res_q.pressure_pa          <= pf;
    res_q.adjusted_pressure_pa <= $signed(pf + off);
    res_q.pressure_invalid     <= sd2_q.invalid;
  end

  assign valid_o = v_q[2];
  assign res_o   = res_q;

endmodule
`default_nettype wire

FILE: rtl/pressure_temperature_compensation.sv
// Top level of the barometric temperature and pressure compensation block.
//
// One raw temperature/pressure pair is taken on every clock edge at which
// start is high; busy stays low, so a new transaction may follow every cycle.
// Each transaction gives exactly one result, shown on res_o for one cycle with
// done_o high, after it has passed 5 stages of temperature polynomial, 6 of
// pressure polynomial, 33 of the bit-per-stage divider and 3 of final
// correction. The receiver cannot stall the block. Calibration words
// are read directly by the stages, so they must only be written while no
// transaction is in flight.
`timescale 1ns / 1ps
`default_nettype none
module pressure_temperature_compensation (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire ptc_pkg::in_t                    in_i,
  output logic                                 done_o,
  output ptc_pkg::out_t                        res_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [ptc_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  wire logic [ptc_pkg::CalWidth-1:0]    cfg_wdata_i
);

  logic [ptc_pkg::CalWidth-1:0] temp_cal_q, cal_a_q, cal_b_q, cal_c_q;
  logic [ptc_pkg::OffWidth-1:0] offset_q;

  logic               t_valid, c_valid, d_valid;
  ptc_pkg::temp_res_t t_res;
  ptc_pkg::div_side_t c_side, d_side;
  logic [31:0]        c_pnum, c_div, d_quot;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_cal_q <= '0;
      cal_a_q    <= '0;
      cal_b_q    <= '0;
      cal_c_q    <= '0;
      offset_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ptc_pkg::RegTempCal: temp_cal_q <= cfg_wdata_i;
        ptc_pkg::RegPressA:  cal_a_q    <= cfg_wdata_i;
        ptc_pkg::RegPressB:  cal_b_q    <= cfg_wdata_i;
        ptc_pkg::RegPressC:  cal_c_q    <= cfg_wdata_i;
        ptc_pkg::RegOffset:  offset_q   <= cfg_wdata_i[ptc_pkg::OffWidth-1:0];
        default: ;
      endcase
    end
  end

  ptc_temp u_temp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (start & ~busy),
    .in_i       (in_i),
    .temp_cal_i (temp_cal_q),
    .valid_o    (t_valid),
    .res_o      (t_res)
  );

  ptc_coef u_coef (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (t_valid),
    .res_i   (t_res),
    .cal_a_i (cal_a_q),
    .cal_b_i (cal_b_q),
    .valid_o (c_valid),
    .side_o  (c_side),
    .pnum_o  (c_pnum),
    .div_o   (c_div)
  );

  ptc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_valid),
    .pnum_i  (c_pnum),
    .div_i   (c_div),
    .side_i  (c_side),
    .valid_o (d_valid),
    .quot_o  (d_quot),
    .side_o  (d_side)
  );

  ptc_final u_final (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (d_valid),
    .quot_i   (d_quot),
    .side_i   (d_side),
    .cal_c_i  (cal_c_q),
    .offset_i (offset_q),
    .valid_o  (done_o),
    .res_o    (res_o)
  );

endmodule
`default_nettype wire

FILE: rtl/ptc_checker.sv
// Port-level checker of the compensation block and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "pressure_temperature_compensation_assert.svh"
module ptc_props (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          done_o,
  input wire ptc_pkg::out_t res_o
);

  `PTC_ASSERT_NEVER(a_never_busy, busy, "busy raised although the pipeline never stalls")
  `PTC_ASSERT_IMP(a_result_follows, start && !busy, ##47 done_o, "transaction produced no result")
  `PTC_ASSERT_IMP(a_no_spurious, done_o, $past(start, 47), "result without a transaction")
  `PTC_ASSERT_IMP(a_invalid_zero, done_o && res_o.pressure_invalid, res_o.pressure_pa == 32'd0, "invalid pressure not zero")

endmodule

bind pressure_temperature_compensation ptc_props u_ptc_props (.*);
`default_nettype wire

FILE: verif/ptc_checker.sv
// Checker that predicts and compares every result of the compensation block.
`timescale 1ns / 1ps
`default_nettype none
module ptc_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  input  wire logic                            busy,
  input  wire ptc_pkg::in_t                    in_i,
  input  wire logic                            done_o,
  input  wire ptc_pkg::out_t                   res_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [ptc_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  wire logic [ptc_pkg::CalWidth-1:0]    cfg_wdata_i,
  output int                                   fail_count_o,
  output int                                   pending_o,
  output int                                   results_seen_o,
  output int                                   invalid_seen_o
);

  logic [ptc_pkg::CalWidth-1:0] temp_cal, press_cal_a, press_cal_b, press_cal_c;
  logic [ptc_pkg::OffWidth-1:0] press_offset;
  ptc_pkg::out_t                expected_results[$];

  function automatic logic [31:0] sra(input logic [31:0] x, input int n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] cal_s(input logic [ptc_pkg::CalWidth-1:0] cal,
                                        input int k);
    logic [15:0] w;
    w = cal[16*k +: 16];
    return {{16{w[15]}}, w};
  endfunction

  // Integer compensation with every intermediate wrapping at 32 bits.
  function automatic ptc_pkg::out_t compensate(input ptc_pkg::in_t item);
    logic [31:0] adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, offs;
    logic [31:0] a, b, d, sq, fine, temp, p, dv;
    ptc_pkg::out_t r;
    adc_t = {12'd0, item.raw_temperature};
    adc_p = {12'd0, item.raw_pressure};
    t1 = {16'd0, temp_cal[15:0]};
    t2 = cal_s(temp_cal, 1);
    t3 = cal_s(temp_cal, 2);
    p1 = {16'd0, press_cal_a[15:0]};
    p2 = cal_s(press_cal_a, 1);
    p3 = cal_s(press_cal_a, 2);
    p4 = cal_s(press_cal_b, 0);
    p5 = cal_s(press_cal_b, 1);
    p6 = cal_s(press_cal_b, 2);
    p7 = cal_s(press_cal_c, 0);
    p8 = cal_s(press_cal_c, 1);
    p9 = cal_s(press_cal_c, 2);
    offs = {{14{press_offset[ptc_pkg::OffWidth-1]}}, press_offset};

    a = sra(((adc_t >> 3) - (t1 << 1)) * t2, 11);
    d = (adc_t >> 4) - t1;
    b = sra(sra(d * d, 12) * t3, 14);
    fine = a + b;
    temp = sra(fine * 32'd5 + 32'd128, 8);

    a = sra(fine, 1) - 32'd64000;
    sq = sra(a, 2) * sra(a, 2);
    b = sra(sq, 11) * p6;
    b = b + ((a * p5) << 1);
    b = sra(b, 2) + (p4 << 16);
    a = sra(sra(p3 * sra(sq, 13), 3) + sra(p2 * a, 1), 18);
    dv = sra((32'd32768 + a) * p1, 15);

    r.pressure_invalid = (dv == 32'd0);
    if (r.pressure_invalid) begin
      p = 32'd0;
    end else begin
      p = ((32'd1048576 - adc_p) - sra(b, 12)) * 32'd3125;
      // The doubling is done before or after the division to stay in 32 bits.
      if (p < 32'h8000_0000) begin
        p = (p << 1) / dv;
      end else begin
        p = (p / dv) * 32'd2;
      end
      a = sra(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
      b = sra((p >> 2) * p8, 13);
      p = p + sra(a + b + p7, 4);
    end
    r.temperature_centi    = temp;
    r.fine_temperature     = fine;
    r.pressure_pa          = p;
    r.adjusted_pressure_pa = p + offs;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ptc_pkg::out_t want;
    if (!rst_ni) begin
      temp_cal       <= '0;
      press_cal_a    <= '0;
      press_cal_b    <= '0;
      press_cal_c    <= '0;
      press_offset   <= '0;
      expected_results.delete();
      fail_count_o   <= 0;
      pending_o      <= 0;
      results_seen_o <= 0;
      invalid_seen_o <= 0;
    end else begin
      if (done_o) begin
        results_seen_o <= results_seen_o + 1;
        if (res_o.pressure_invalid) invalid_seen_o <= invalid_seen_o + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, res_o);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_results.pop_front();
          if (want !== res_o) begin
            $display("%0t: mismatch expected temp %0d fine %0d p %0d adj %0d inv %b",
                     $time, want.temperature_centi, want.fine_temperature,
                     want.pressure_pa, want.adjusted_pressure_pa, want.pressure_invalid);
            $display("%0t:          actual temp %0d fine %0d p %0d adj %0d inv %b",
                     $time, res_o.temperature_centi, res_o.fine_temperature,
                     res_o.pressure_pa, res_o.adjusted_pressure_pa, res_o.pressure_invalid);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (start && !busy) expected_results.push_back(compensate(in_i));
      pending_o <= expected_results.size();
      if (cfg_we_i) begin
        unique case (ptc_pkg::cfg_reg_e'(cfg_index_i))
          ptc_pkg::RegTempCal: temp_cal     <= cfg_wdata_i;
          ptc_pkg::RegPressA:  press_cal_a  <= cfg_wdata_i;
          ptc_pkg::RegPressB:  press_cal_b  <= cfg_wdata_i;
          ptc_pkg::RegPressC:  press_cal_c  <= cfg_wdata_i;
          ptc_pkg::RegOffset:  press_offset <= cfg_wdata_i[ptc_pkg::OffWidth-1:0];
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

FILE: verif/tb_top.sv
// Testbench top: stimulus, configuration phases and verdict for the compensation block.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            start = 1'b0;
  logic                            busy;
  ptc_pkg::in_t                    in_i = '0;
  logic                            done_o;
  ptc_pkg::out_t                   res_o;
  logic                            cfg_we_i = 1'b0;
  logic [ptc_pkg::CfgIdxWidth-1:0] cfg_index_i = '0;
  logic [ptc_pkg::CalWidth-1:0]    cfg_wdata_i = '0;
  logic                            busy_last = 1'b0;
  int                              fail_count, pending, results_seen, invalid_seen;
  int                              items_sent = 0;
  int                              phases_run = 0;

  always #1 clk_i = ~clk_i;
  always @(negedge clk_i) busy_last <= busy;

  pressure_temperature_compensation u_dut (
    .clk_i, .rst_ni, .start, .busy, .in_i, .done_o, .res_o,
    .cfg_we_i, .cfg_index_i, .cfg_wdata_i
  );

  ptc_checker u_checker (
    .clk_i, .rst_ni, .start, .busy, .in_i, .done_o, .res_o,
    .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_seen_o (results_seen),
    .invalid_seen_o (invalid_seen)
  );

  task automatic send_sample(input ptc_pkg::in_t v, input bit may_idle);
    while (may_idle && $urandom_range(0, 99) < 35) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    in_i  <= v;
    do @(posedge clk_i); while (busy_last);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (ptc_pkg::Latency + 4) @(posedge clk_i);
  endtask

  // Each write drops the write enable again before the task returns.
  task automatic write_reg(input ptc_pkg::cfg_reg_e idx,
                           input logic [ptc_pkg::CalWidth-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [ptc_pkg::CalWidth-1:0] pack3(input int w2, input int w1,
                                                          input int w0);
    return {w2[15:0], w1[15:0], w0[15:0]};
  endfunction

  // Typical factory calibration, optionally jittered.
  task automatic load_typical(input int jitter, input int offs);
    write_reg(ptc_pkg::RegTempCal, pack3(-1000 + $urandom_range(0, jitter),
                                         26435 - $urandom_range(0, jitter), 27504));
    write_reg(ptc_pkg::RegPressA, pack3(3024, -10685 + $urandom_range(0, jitter),
                                        36477 - $urandom_range(0, jitter)));
    write_reg(ptc_pkg::RegPressB, pack3(-7, 140, 2855 + $urandom_range(0, jitter)));
    write_reg(ptc_pkg::RegPressC, pack3(6000, -14600, 15500));
    write_reg(ptc_pkg::RegOffset, 48'(offs));
  endtask

  task automatic load_random();
    write_reg(ptc_pkg::RegTempCal, 48'({$urandom, $urandom}));
    write_reg(ptc_pkg::RegPressA, 48'({$urandom, $urandom}));
    write_reg(ptc_pkg::RegPressB, 48'({$urandom, $urandom}));
    write_reg(ptc_pkg::RegPressC, 48'({$urandom, $urandom}));
    write_reg(ptc_pkg::RegOffset, 48'({$urandom, $urandom}));
  endtask

  function automatic ptc_pkg::in_t near_typical();
    ptc_pkg::in_t v;
    v.raw_temperature = 20'(519888 + $urandom_range(0, 200000) - 100000);
    v.raw_pressure    = 20'(415148 + $urandom_range(0, 200000) - 100000);
    return v;
  endfunction

  task automatic random_phase(input int count, input bit typical, input bit may_idle);
    ptc_pkg::in_t v;
    for (int i = 0; i < count; i++) begin
      if (typical && $urandom_range(0, 3) != 0) v = near_typical();
      else v = 40'({$urandom, $urandom});
      send_sample(v, may_idle);
      // In the second random phase only, hold off once mid-phase until the pipeline is empty.
      if (i == count / 2 && phases_run == 1) drain();
    end
    drain();
    phases_run++;
  endtask

  initial begin
    ptc_pkg::in_t edges[4];
    edges[0] = {20'h00000, 20'h00000};
    edges[1] = {20'hFFFFF, 20'hFFFFF};
    edges[2] = {20'h00000, 20'hFFFFF};
    edges[3] = {20'hFFFFF, 20'h00000};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset calibration: divisor is zero, every pressure is invalid.
    foreach (edges[i]) send_sample(edges[i], 1'b0);
    drain();
    load_typical(0, 100000);
    foreach (edges[i]) send_sample(edges[i], 1'b1);
    repeat (4) send_sample(near_typical(), 1'b0);
    send_sample({20'd519888, 20'd415148}, 1'b0);
    drain();
    // All-ones calibration and the most negative offset pattern.
    write_reg(ptc_pkg::RegTempCal, '1);
    write_reg(ptc_pkg::RegPressA, '1);
    write_reg(ptc_pkg::RegPressB, '1);
    write_reg(ptc_pkg::RegPressC, '1);
    write_reg(ptc_pkg::RegOffset, 48'h2_0000);
    foreach (edges[i]) send_sample(edges[i], 1'b0);
    drain();
    // Writes to unused indexes must leave the calibration untouched.
    for (int k = int'(ptc_pkg::RegOffset) + 1; k < (1 << ptc_pkg::CfgIdxWidth); k++) begin
      write_reg(ptc_pkg::cfg_reg_e'(k), '0);
    end
    load_typical(0, -100000);
    write_reg(ptc_pkg::RegPressA, pack3(0, 0, 1));
    foreach (edges[i]) send_sample(edges[i], 1'b1);
    drain();

    load_typical(2000, 1234);
    random_phase(150, 1'b1, 1'b1);
    load_typical(8000, -100000);
    random_phase(150, 1'b1, 1'b0);
    load_random();
    random_phase(150, 1'b0, 1'b1);
    load_random();
    write_reg(ptc_pkg::RegPressA, {$urandom, 16'($urandom_range(1, 4))});
    random_phase(150, 1'b0, 1'b1);
    load_typical(500, 100000);
    write_reg(ptc_pkg::RegOffset, 48'h1_FFFF);
    random_phase(150, 1'b1, 1'b1);
    load_random();
    random_phase(150, 1'b0, 1'b1);
    load_typical(30000, 0);
    random_phase(130, 1'b1, 1'b1);

    $display("Sent %0d samples over %0d random phases;", items_sent, phases_run);
    $display("%0d results came back, %0d with invalid pressure.",
             results_seen, invalid_seen);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("tb_top failed");
    $finish;
  end
endmodule
`default_nettype wire
